>>> sv/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// Shared constants and word types for the segment intersection core.
// ----------------------------------------------------------------------------
`default_nettype none

package sic_pkg;

  localparam int COORD_WIDTH         = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int BOUND_WIDTH         = 19;
  localparam int CFG_INDEX_WIDTH     = 1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [BOUND_WIDTH-1:0] bound_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_LOW_BOUND  = 1'b0,
    CFG_HIGH_BOUND = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    coord_t first_start_x;
    coord_t first_start_y;
    coord_t first_end_x;
    coord_t first_end_y;
    coord_t second_start_x;
    coord_t second_start_y;
    coord_t second_end_x;
    coord_t second_end_y;
  } seg_in_t;

  typedef struct packed {
    logic   hit;
    coord_t point_x;
    coord_t point_y;
  } seg_out_t;

endpackage

`default_nettype wire

>>> sv/segment_intersection_core.sv
// ----------------------------------------------------------------------------
// segment_intersection_core
// 2D segment intersection in fixed point with configurable parameter bounds.
// ----------------------------------------------------------------------------
// One word is taken every cycle (busy never rises); its result appears on
// result with done high once it has passed stages 1 to 5, the divider (one
// cell per quotient bit) and stages 6 to 8. Results cannot be stalled: the
// receiver must take done as it comes.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_core #(
  parameter int PARAM_FRAC_BITS = sic_pkg::PARAM_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire sic_pkg::seg_in_t                    seg_in,
  output logic                                     done,
  output sic_pkg::seg_out_t                        result,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sic_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [sic_pkg::BOUND_WIDTH-1:0]     cfg_data
);

  import sic_pkg::*;

  localparam int F    = PARAM_FRAC_BITS;
  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int MW   = 2 * DW;
  localparam int NW   = MW + 1;
  localparam int BW   = BOUND_WIDTH;
  localparam int QB   = BOUND_WIDTH;
  localparam int DVW  = NW - 1;
  localparam int RW   = NW - 1 + F + QB;
  localparam int CMPW = NW + F + BW;
  localparam int PPW  = QB + 1 + DW;
  localparam int SW   = PPW + 2;

  typedef struct packed {
    logic                 ok;
    logic                 neg;
    coord_t               ax;
    coord_t               ay;
    logic signed [DW-1:0] abx;
    logic signed [DW-1:0] aby;
  } side_t;

  bound_t lo_bound;
  bound_t hi_bound;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_bound <= '0;
      hi_bound <= BW'(1) << F;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOW_BOUND:  lo_bound <= cfg_data;
        CFG_HIGH_BOUND: hi_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: differences
  logic                 v1;
  coord_t               ax1, ay1;
  logic signed [DW-1:0] abx1, aby1, cdx1, cdy1, acx1, acy1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    ax1  <= seg_in.first_start_x;
    ay1  <= seg_in.first_start_y;
    abx1 <= DW'(seg_in.first_end_x) - DW'(seg_in.first_start_x);
    aby1 <= DW'(seg_in.first_end_y) - DW'(seg_in.first_start_y);
    cdx1 <= DW'(seg_in.second_end_x) - DW'(seg_in.second_start_x);
    cdy1 <= DW'(seg_in.second_end_y) - DW'(seg_in.second_start_y);
    acx1 <= DW'(seg_in.second_start_x) - DW'(seg_in.first_start_x);
    acy1 <= DW'(seg_in.second_start_y) - DW'(seg_in.first_start_y);
  end

  // stage 2: cross products
  logic                 v2;
  coord_t               ax2, ay2;
  logic signed [DW-1:0] abx2, aby2;
  logic signed [MW-1:0] pa2, pb2, pc2, pd2, pe2, pf2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    ax2  <= ax1;
    ay2  <= ay1;
    abx2 <= abx1;
    aby2 <= aby1;
    pa2  <= abx1 * cdy1;
    pb2  <= aby1 * cdx1;
    pc2  <= cdy1 * acx1;
    pd2  <= cdx1 * acy1;
    pe2  <= abx1 * acy1;
    pf2  <= aby1 * acx1;
  end

  // stage 3: denominator and numerators, sign normalised
  logic signed [NW-1:0] den_raw, n1_raw, n2_raw;
  logic                 v3, nz3;
  coord_t               ax3, ay3;
  logic signed [DW-1:0] abx3, aby3;
  logic signed [NW-1:0] den3, n13, n23;

  assign den_raw = NW'(pa2) - NW'(pb2);
  assign n1_raw  = NW'(pc2) - NW'(pd2);
  assign n2_raw  = NW'(pe2) - NW'(pf2);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    ax3  <= ax2;
    ay3  <= ay2;
    abx3 <= abx2;
    aby3 <= aby2;
    nz3  <= (den_raw != '0);
    den3 <= den_raw[NW-1] ? -den_raw : den_raw;
    n13  <= den_raw[NW-1] ? -n1_raw  : n1_raw;
    n23  <= den_raw[NW-1] ? -n2_raw  : n2_raw;
  end

  // stage 4: scaled bounds
  logic                    v4, nz4;
  coord_t                  ax4, ay4;
  logic signed [DW-1:0]    abx4, aby4;
  logic signed [NW-1:0]    den4, n14, n24;
  logic signed [BW+NW-1:0] lod4, hid4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    ax4  <= ax3;
    ay4  <= ay3;
    abx4 <= abx3;
    aby4 <= aby3;
    nz4  <= nz3;
    den4 <= den3;
    n14  <= n13;
    n24  <= n23;
    lod4 <= lo_bound * den3;
    hid4 <= hi_bound * den3;
  end

  // stage 5: bound test, divider operands
  logic signed [CMPW-1:0] ns1, ns2, lo_c, hi_c;
  logic signed [NW-1:0]   abs_n1;
  logic                   in_ok;
  logic                   v5;
  side_t                  sd5;
  logic [RW-1:0]          mag5;
  logic [DVW-1:0]         den5;

  assign ns1    = CMPW'(n14) <<< F;
  assign ns2    = CMPW'(n24) <<< F;
  assign lo_c   = CMPW'(lod4);
  assign hi_c   = CMPW'(hid4);
  assign abs_n1 = n14[NW-1] ? -n14 : n14;
  assign in_ok  = nz4 && (ns1 >= lo_c) && (ns1 <= hi_c) && (ns2 >= lo_c) && (ns2 <= hi_c);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    sd5.ok  <= in_ok;
    sd5.neg <= n14[NW-1];
    sd5.ax  <= ax4;
    sd5.ay  <= ay4;
    sd5.abx <= abx4;
    sd5.aby <= aby4;
    mag5    <= RW'(abs_n1[NW-2:0]) << F;
    den5    <= den4[NW-2:0];
  end

  // divider and matching side line
  logic          vq;
  logic [QB-1:0] quo;
  logic [RW-1:0] rem;
  side_t         sd_line [QB];

  sic_divider #(
    .RW (RW),
    .DVW(DVW),
    .QB (QB)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .dividend (mag5),
    .divisor  (den5),
    .out_valid(vq),
    .quotient (quo),
    .remainder(rem)
  );

  always_ff @(posedge clk) begin
    sd_line[0] <= sd5;
    for (int i = 1; i < QB; i++) begin
      sd_line[i] <= sd_line[i-1];
    end
  end

  // stage 6: floored parameter
  logic signed [QB:0] qs;
  logic               v6;
  side_t              sd6;
  logic signed [QB:0] t1q6;

  assign qs = $signed({1'b0, quo});

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= vq;
    sd6  <= sd_line[QB-1];
    t1q6 <= sd_line[QB-1].neg ? (-qs - (QB+1)'(rem != '0)) : qs;
  end

  // stage 7: offsets
  logic                  v7;
  side_t                 sd7;
  logic signed [PPW-1:0] offx7, offy7;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    sd7   <= sd6;
    offx7 <= t1q6 * sd6.abx;
    offy7 <= t1q6 * sd6.aby;
  end

  // stage 8: point, saturate, output
  logic signed [SW-1:0] sumx, sumy;
  coord_t               satx, saty;

  assign sumx = SW'(sd7.ax) + SW'(offx7 >>> F);
  assign sumy = SW'(sd7.ay) + SW'(offy7 >>> F);

  always_comb begin
    satx = sumx[CW-1:0];
    saty = sumy[CW-1:0];
    if (sumx[SW-1:CW-1] != {(SW-CW+1){sumx[SW-1]}}) begin
      satx = {sumx[SW-1], {(CW-1){~sumx[SW-1]}}};
    end
    if (sumy[SW-1:CW-1] != {(SW-CW+1){sumy[SW-1]}}) begin
      saty = {sumy[SW-1], {(CW-1){~sumy[SW-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v7;
    result.hit     <= sd7.ok;
    result.point_x <= sd7.ok ? satx : '0;
    result.point_y <= sd7.ok ? saty : '0;
  end

endmodule

`default_nettype wire

>>> sv/sic_div_cell.sv
// ----------------------------------------------------------------------------
// sic_div_cell
// One restoring division step: resolves a single quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_div_cell #(
  parameter int RW    = 72,
  parameter int DVW   = 34,
  parameter int QB    = 19,
  parameter int SHIFT = 0
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [RW-1:0]  rem_in,
  input  wire logic [DVW-1:0] den_in,
  input  wire logic [QB-1:0]  quo_in,
  output logic                out_valid,
  output logic [RW-1:0]       rem_out,
  output logic [DVW-1:0]      den_out,
  output logic [QB-1:0]       quo_out
);

  logic [RW:0] sub_den;
  logic [RW:0] trial;
  logic        take;

  assign sub_den = (RW+1)'(den_in) << SHIFT;
  assign trial   = {1'b0, rem_in} - sub_den;
  assign take    = ~trial[RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    rem_out <= take ? trial[RW-1:0] : rem_in;
    den_out <= den_in;
    quo_out <= quo_in | (take ? (QB'(1) << SHIFT) : QB'(0));
  end

endmodule

`default_nettype wire

>>> sv/sic_divider.sv
// ----------------------------------------------------------------------------
// sic_divider
// Chain of division cells, MSB first; takes a new word every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_divider #(
  parameter int RW  = 72,
  parameter int DVW = 34,
  parameter int QB  = 19
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [RW-1:0]  dividend,
  input  wire logic [DVW-1:0] divisor,
  output logic                out_valid,
  output logic [QB-1:0]       quotient,
  output logic [RW-1:0]       remainder
);

  logic           vld_c [QB+1];
  logic [RW-1:0]  rem_c [QB+1];
  logic [DVW-1:0] den_c [QB+1];
  logic [QB-1:0]  quo_c [QB+1];

  assign vld_c[0] = in_valid;
  assign rem_c[0] = dividend;
  assign den_c[0] = divisor;
  assign quo_c[0] = '0;

  for (genvar i = 0; i < QB; i++) begin : g_cell
    sic_div_cell #(
      .RW   (RW),
      .DVW  (DVW),
      .QB   (QB),
      .SHIFT(QB-1-i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (vld_c[i]),
      .rem_in   (rem_c[i]),
      .den_in   (den_c[i]),
      .quo_in   (quo_c[i]),
      .out_valid(vld_c[i+1]),
      .rem_out  (rem_c[i+1]),
      .den_out  (den_c[i+1]),
      .quo_out  (quo_c[i+1])
    );
  end

  assign out_valid = vld_c[QB];
  assign quotient  = quo_c[QB];
  assign remainder = rem_c[QB];

endmodule

`default_nettype wire
